>>> rtl/core/log_record_header_checker_core_assert.svh
// Assertion macros shared by the log record header checker RTL.
// Every user must have clk and rst in scope.
`ifndef LOG_RECORD_HEADER_CHECKER_CORE_ASSERT_SVH
`define LOG_RECORD_HEADER_CHECKER_CORE_ASSERT_SVH

// Condition that holds at every edge outside reset.
`define LRHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define LRHC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LRHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/lrhc_pkg.sv
// Shared types and constants for the log record header checker.
// No dependencies.
package lrhc_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int POS_W        = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 64;

  localparam logic [POS_W-1:0] POS_VERSION   = POS_W'(8);
  localparam logic [POS_W-1:0] POS_PID       = POS_W'(12);
  localparam logic [POS_W-1:0] POS_LEN       = POS_W'(16);
  localparam logic [POS_W-1:0] POS_PAYLOAD   = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_LAST_HDR  = POS_W'(HEADER_BYTES - 1);

  localparam logic [63:0] MAGIC_RESET   = 64'h5446_4152_4F4B_414D;
  localparam logic [7:0]  VERSION_RESET = 8'd1;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC   = 1'b0,
    REG_VERSION = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_VERSION   = 3'd3,
    ST_RESERVED  = 3'd4,
    ST_TOO_LARGE = 3'd5,
    ST_MISMATCH  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_PID     = 2'd1,
    KIND_LEN     = 2'd2,
    KIND_PAYLOAD = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    kind_t      kind;
    logic [1:0] lane;
    status_t    fault;
    logic       short_rec;
  } token_t;

endpackage

>>> rtl/core/lrhc_if.sv
// Byte and result channel interfaces for the log record header checker.
// Depends on nothing; carries valid/ready and the beat payload.
interface lrhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface lrhc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        record_done;
  logic [2:0]  status;
  logic [31:0] part_id;
  logic [30:0] payload_length;

  modport source(output valid, payload_byte, payload_valid, record_done, status,
                 part_id, payload_length, input ready);
  modport sink(input valid, payload_byte, payload_valid, record_done, status,
               part_id, payload_length, output ready);
endinterface

>>> rtl/core/lrhc_queue.sv
// Short token queue between the front and back stages.
// Depends on lrhc_pkg and the assertion macro header.
`include "log_record_header_checker_core_assert.svh"

module lrhc_queue
  import lrhc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_tok,
  output logic   full,
  input  logic   pop,
  output logic   tok_valid,
  output token_t tok
);

  token_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign tok_valid = (count != '0);
  assign tok       = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && tok_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `LRHC_ASSERT(a_count_bound, count <= Q_CNT_W'(Q_DEPTH), "queue count past depth")
  `LRHC_ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + 1'b1,
                    "queue count missed a push")
  `LRHC_ASSERT_NEXT(a_count_down, do_pop && !do_push, count == $past(count) - 1'b1,
                    "queue count missed a pop")

endmodule

>>> rtl/core/lrhc_front.sv
// Front stage: holds the config registers, tracks header offset and
// classifies each byte into a token. Depends on lrhc_pkg.
module lrhc_front
  import lrhc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic [7:0]            in_data,
  input  logic                  in_last,
  output logic                  in_ready,
  input  logic                  q_full,
  output logic                  push,
  output token_t                push_tok
);

  logic [63:0]      expected_magic;
  logic [7:0]       expected_version;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             is_payload;
  logic [7:0]       magic_byte;

  assign in_ready   = !q_full;
  assign push       = in_valid && in_ready;
  assign is_payload = (pos >= POS_PAYLOAD);
  assign magic_byte = expected_magic[{pos[2:0], 3'b000} +: 8];

  always_comb begin
    push_tok.data      = in_data;
    push_tok.last      = in_last;
    push_tok.lane      = pos[1:0];
    push_tok.fault     = ST_OK;
    push_tok.short_rec = !is_payload && (pos < POS_LAST_HDR);
    priority if (is_payload) begin
      push_tok.kind = KIND_PAYLOAD;
    end else if (pos >= POS_LEN) begin
      push_tok.kind = KIND_LEN;
    end else if (pos >= POS_PID) begin
      push_tok.kind = KIND_PID;
    end else begin
      push_tok.kind = KIND_HDR;
      priority if (pos < POS_VERSION) begin
        if (in_data != magic_byte) push_tok.fault = ST_MAGIC;
      end else if (pos == POS_VERSION) begin
        if (in_data != expected_version) push_tok.fault = ST_VERSION;
      end else begin
        if (in_data != 8'd0) push_tok.fault = ST_RESERVED;
      end
    end
  end

  always_comb begin
    pos_next = pos;
    if (push) begin
      if (in_last) begin
        pos_next = '0;
      end else if (!is_payload) begin
        pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= '0;
      expected_magic   <= MAGIC_RESET;
      expected_version <= VERSION_RESET;
    end else begin
      pos <= pos_next;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MAGIC:   expected_magic   <= cfg_data;
          REG_VERSION: expected_version <= cfg_data[7:0];
          default:     expected_magic   <= expected_magic;
        endcase
      end
    end
  end

endmodule

>>> rtl/core/lrhc_back.sv
// Back stage: assembles partition id and length, counts payload, resolves
// status and drives the result register. Uses lrhc_pkg, lrhc_if, macros.
`include "log_record_header_checker_core_assert.svh"

module lrhc_back
  import lrhc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  input  token_t        tok,
  output logic          pop,
  lrhc_out_if.source    results
);

  status_t     first_error;
  logic [31:0] partition;
  logic [31:0] length;
  logic [31:0] count;
  status_t     err_eff;
  logic [31:0] pid_eff;
  logic [31:0] len_eff;
  logic [31:0] count_eff;
  status_t     st;
  logic        is_payload;

  assign pop        = tok_valid && (!results.valid || results.ready);
  assign is_payload = (tok.kind == KIND_PAYLOAD);
  assign err_eff    = (first_error != ST_OK) ? first_error : tok.fault;

  always_comb begin
    pid_eff = partition;
    len_eff = length;
    if (tok.kind == KIND_PID) begin
      pid_eff[{tok.lane, 3'b000} +: 8] = partition[{tok.lane, 3'b000} +: 8] | tok.data;
    end
    if (tok.kind == KIND_LEN) begin
      len_eff[{tok.lane, 3'b000} +: 8] = length[{tok.lane, 3'b000} +: 8] | tok.data;
    end
    count_eff = (is_payload && count != '1) ? count + 32'd1 : count;
  end

  always_comb begin
    priority if (tok.short_rec) begin
      st = ST_SHORT;
    end else if (err_eff != ST_OK) begin
      st = err_eff;
    end else if (len_eff[31]) begin
      st = ST_TOO_LARGE;
    end else if (count_eff != len_eff) begin
      st = ST_MISMATCH;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_error   <= ST_OK;
      partition     <= '0;
      length        <= '0;
      count         <= '0;
      results.valid <= 1'b0;
    end else begin
      if (pop) begin
        results.valid <= 1'b1;
        if (tok.last) begin
          first_error <= ST_OK;
          partition   <= '0;
          length      <= '0;
          count       <= '0;
        end else begin
          first_error <= err_eff;
          partition   <= pid_eff;
          length      <= len_eff;
          count       <= count_eff;
        end
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      results.payload_byte   <= is_payload ? tok.data : 8'd0;
      results.payload_valid  <= is_payload;
      results.record_done    <= tok.last;
      results.status         <= tok.last ? st : ST_OK;
      results.part_id        <= tok.last ? pid_eff : 32'd0;
      results.payload_length <= (tok.last && st == ST_OK) ? len_eff[30:0] : 31'd0;
    end
  end

  `LRHC_ASSERT_NEXT(a_clear_on_last, pop && tok.last,
                    first_error == ST_OK && count == '0 && length == '0,
                    "record state not cleared after final beat")
  `LRHC_ASSERT_IMPL(a_len_only_ok, results.valid && results.status != ST_OK,
                    results.payload_length == '0, "length reported with a fault")
  `LRHC_ASSERT_IMPL(a_quiet_mid_record, results.valid && !results.record_done,
                    results.status == ST_OK && results.part_id == '0,
                    "status or id shown before final beat")

endmodule

>>> rtl/core/log_record_header_checker_core.sv
// Log record header checker, top level.
// Depends on lrhc_pkg, lrhc_if, lrhc_front, lrhc_queue and lrhc_back.
//
// records carries one byte of an encoded log record per beat, last_byte set
// on the final byte. results carries exactly one beat per input beat: the
// byte passed through when it lies past the 20-byte header, and on the
// final beat the status, partition id and declared length (0 on a fault).
// The configuration port writes the expected magic (index 0) and version
// (index 1); write only while no record is in flight.
// A result passes through the token queue and then the result register.
// Throughput: 1 byte per cycle while results is not stalled, set by the back
// stage taking one token a cycle into its result register.
// A 4-entry token queue sits between the front and back stages; when
// results stalls, records keeps accepting until the queue fills, then
// ready drops and rises again the cycle after one result beat is taken.
// Reset (synchronous, active high) clears the record state and queue and
// loads the default magic and version 1.
module log_record_header_checker_core
  import lrhc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lrhc_in_if.sink               records,
  lrhc_out_if.source            results
);

  logic   push;
  token_t push_tok;
  logic   q_full;
  logic   pop;
  logic   tok_valid;
  token_t tok;

  lrhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (records.valid),
    .in_data   (records.data_byte),
    .in_last   (records.last_byte),
    .in_ready  (records.ready),
    .q_full    (q_full),
    .push      (push),
    .push_tok  (push_tok)
  );

  lrhc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tok  (push_tok),
    .full      (q_full),
    .pop       (pop),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  lrhc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .pop       (pop),
    .results   (results)
  );

endmodule
